@@ src/jsrl_pkg.sv @@
`default_nettype none

package jsrl_pkg;

	localparam int JOINTS = 7;
	// commands per tick are capped at seven
	localparam int ACTIVE = (JOINTS < 7) ? JOINTS : 7;
	localparam int AW = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

	localparam int POS_W = 32;
	localparam int LIM_W = 31;
	localparam int QBITS = 31;
	localparam int CNT_W = 5;

	typedef enum logic {
		REG_STEP_LIMIT = 1'b0,
		REG_REACH_TOL  = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		REQ_GOAL = 1'b0,
		REQ_MEAS = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAXP,
		ST_LOAD,
		ST_MULT,
		ST_DIV,
		ST_EMIT
	} state_t;

	localparam logic [LIM_W-1:0] STEP_LIMIT_RST = 31'd16777;
	localparam logic [LIM_W-1:0] REACH_TOL_RST  = 31'd1677;

endpackage

`default_nettype wire

@@ src/joint_step_rate_limiter.sv @@
`default_nettype none

// Joint step rate limiter. Goal words (req_type 0) store a per-joint goal and arm the
// block; measured words (req_type 1) store a per-joint measurement. A measured word with
// tick_end set starts one tick: the block finds the largest |goal - measured| over all
// joints and, when it exceeds step_limit, scales every step by step_limit / max (quotient
// truncated toward zero). It then emits one result word per joint, in joint order, with
// command_position = measured + step (saturated to 32 bits), joint_reached when the
// |step| <= reach_tolerance while armed, and last_joint on the final joint. Before any
// goal arrives the step is zero and joint_reached is 0. A tick runs the max search over
// all ACTIVE joints, then per joint a load and an emit step when no scaling is needed, or
// load, one registered multiply, 31 steps of a shared restoring divider and emit when it
// is; a stalled output holds the emit step. in_stall is high for the whole tick. The
// last result may sit in the output register while new words are taken. Configuration
// (index 0 step_limit, index 1 reach_tolerance, Q7.24) is always ready and must only be
// written while the block is idle.

module joint_step_rate_limiter
	import jsrl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [LIM_W-1:0]  cfg_data,

	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              req_type,
	input  wire logic [2:0]        joint_index,
	input  wire logic signed [POS_W-1:0] position,
	input  wire logic              tick_end,

	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [2:0]             out_joint,
	output logic signed [POS_W-1:0] command_position,
	output logic                   joint_reached,
	output logic                   last_joint
);

	localparam logic [AW-1:0] LAST_IDX = AW'(ACTIVE - 1);
	localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
	localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

	// configuration
	logic [LIM_W-1:0] step_limit_q;
	logic [LIM_W-1:0] reach_tol_q;

	// joint stores
	logic signed [POS_W-1:0] goal_q [ACTIVE];
	logic signed [POS_W-1:0] meas_q [ACTIVE];
	logic                    armed_q;

	// sequencer
	state_t          state_q, state_d;
	logic [AW-1:0]   idx_q;
	logic            in_fire;
	logic            emit_fire;

	// datapath
	logic [32:0]             maxd_q;
	logic                    scale_q;
	logic [32:0]             mag_q;
	logic                    neg_q;
	logic signed [POS_W-1:0] cur_meas_q;
	logic [32:0]             rem_q;
	logic [QBITS-1:0]        low_q;
	logic [QBITS-1:0]        quo_q;
	logic [CNT_W-1:0]        cnt_q;

	// output register
	logic                    out_valid_q;
	logic [2:0]              out_joint_q;
	logic signed [POS_W-1:0] cmd_q;
	logic                    reached_q;
	logic                    last_q;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_limit_q <= STEP_LIMIT_RST;
			reach_tol_q  <= REACH_TOL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_STEP_LIMIT: step_limit_q <= cfg_data;
				REG_REACH_TOL:  reach_tol_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stores: out-of-range joints are dropped, and a dropped goal does not arm
	logic idx_ok;
	assign idx_ok = 32'(joint_index) < ACTIVE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ACTIVE; i++) goal_q[i] <= '0;
			armed_q <= 1'b0;
		end else if (in_fire && req_type == REQ_GOAL && idx_ok) begin
			goal_q[joint_index[AW-1:0]] <= position;
			armed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && req_type == REQ_MEAS && idx_ok)
			meas_q[joint_index[AW-1:0]] <= position;
	end

	// difference of the joint under the counter
	logic signed [32:0] diff;
	logic [32:0]        diff_mag;
	logic [32:0]        new_max;

	always_comb begin
		diff     = armed_q ? (33'(goal_q[idx_q]) - 33'(meas_q[idx_q])) : '0;
		diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
		new_max  = (diff_mag > maxd_q) ? diff_mag : maxd_q;
	end

	// shared multiply and restoring divide step
	logic [63:0] product;
	logic [33:0] trial;
	logic        trial_ge;

	assign product  = 64'(mag_q) * 64'(step_limit_q);
	assign trial    = {rem_q, low_q[QBITS-1]};
	assign trial_ge = trial >= {1'b0, maxd_q};

	// command for the current joint
	logic [32:0]        step_mag;
	logic signed [33:0] step_s;
	logic signed [33:0] cmd_sum;
	logic signed [POS_W-1:0] cmd_sat;
	logic               reached;

	always_comb begin
		step_mag = scale_q ? {2'b00, quo_q} : mag_q;
		step_s   = neg_q ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
		cmd_sum  = 34'(cur_meas_q) + step_s;
		if (cmd_sum > SAT_MAX)
			cmd_sat = POS_W'(SAT_MAX);
		else if (cmd_sum < SAT_MIN)
			cmd_sat = POS_W'(SAT_MIN);
		else
			cmd_sat = cmd_sum[POS_W-1:0];
		reached = armed_q && (step_mag <= {2'b00, reach_tol_q});
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		emit_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && req_type == REQ_MEAS && tick_end)
					state_d = ST_MAXP;
			end
			ST_MAXP: begin
				if (idx_q == LAST_IDX)
					state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = scale_q ? ST_MULT : ST_EMIT;
			end
			ST_MULT: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit_fire = 1'b1;
					state_d   = (idx_q == LAST_IDX) ? ST_IDLE : ST_LOAD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			scale_q <= 1'b0;
			maxd_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q  <= '0;
					maxd_q <= '0;
				end
				ST_MAXP: begin
					maxd_q <= new_max;
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						scale_q <= armed_q && (new_max > {2'b00, step_limit_q});
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_fire && idx_q != LAST_IDX)
						idx_q <= idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload of the joint datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				mag_q      <= diff_mag;
				neg_q      <= diff[32];
				cur_meas_q <= meas_q[idx_q];
			end
			ST_MULT: begin
				// quotient fits 31 bits, so the top of the product is below maxd
				rem_q <= product[63:QBITS];
				low_q <= product[QBITS-1:0];
				quo_q <= '0;
				cnt_q <= CNT_W'(QBITS - 1);
			end
			ST_DIV: begin
				rem_q <= trial_ge ? 33'(trial - {1'b0, maxd_q}) : trial[32:0];
				low_q <= {low_q[QBITS-2:0], 1'b0};
				quo_q <= {quo_q[QBITS-2:0], trial_ge};
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_fire)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_joint_q <= 3'(idx_q);
			cmd_q       <= cmd_sat;
			reached_q   <= reached;
			last_q      <= (idx_q == LAST_IDX);
		end
	end

	assign out_valid        = out_valid_q;
	assign out_joint        = out_joint_q;
	assign command_position = cmd_q;
	assign joint_reached    = reached_q;
	assign last_joint       = last_q;

	// divider remainder stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < maxd_q))
		else $error("divider remainder not below divisor");

	// a new result only comes from the emit step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result word appeared outside emit");

	// last flag marks the final joint
	a_last_joint: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (out_joint_q == 3'(LAST_IDX)))
		else $error("last_joint on wrong joint");

endmodule

`default_nettype wire

@@ tb/sv/joint_step_rate_limiter_test.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the joint step rate limiter.
// A local model tracks goals, measurements, arming and both limit registers; every
// accepted input word runs through it and each tick queues the seven joint commands
// it should produce. Output words are popped and compared field by field.
module joint_step_rate_limiter_test;
	import jsrl_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	// allowance for the longest tick, a scaled divide for every joint, plus margin
	localparam int TICK_DRAIN = 300;
	localparam int PHASE_WORDS = 16;
	localparam int PHASES = 5;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [2:0]         joint;
		logic signed [31:0] cmd;
		logic               reached;
		logic               last;
	} cmd_word_t;

	// one directed word; when hand_set is high the tick it ends is expected to command
	// every joint to hand_cmd with hand_reached, instead of what the model works out
	typedef struct packed {
		req_t        kind;
		logic [2:0]  joint;
		logic [31:0] pos;
		logic        tick;
		logic        hand_set;
		logic [31:0] hand_cmd;
		logic        hand_reached;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                   cfg_valid;
	logic                   cfg_ready;
	logic                   cfg_index;
	logic [LIM_W-1:0]       cfg_data;

	logic                   in_valid;
	logic                   in_stall;
	logic                   req_type;
	logic [2:0]             joint_index;
	logic signed [POS_W-1:0] position;
	logic                   tick_end;

	logic                   out_valid;
	logic                   out_stall;
	logic [2:0]             out_joint;
	logic signed [POS_W-1:0] command_position;
	logic                   joint_reached;
	logic                   last_joint;

	// hand-typed expectation riding along with the input word
	logic                   hand_set;
	logic [31:0]            hand_cmd;
	logic                   hand_reached;

	// model state
	logic signed [31:0]     goal_pos [ACTIVE];
	logic signed [31:0]     meas_pos [ACTIVE];
	logic                   goal_armed;
	logic [LIM_W-1:0]       step_limit_q;
	logic [LIM_W-1:0]       reach_tol_q;

	cmd_word_t              expected_cmds [$];
	plan_row_t              plan [$];

	int                     mismatches = 0;
	int unsigned            cycle_count = 0;
	int                     words_sent = 0;
	logic                   sender_gaps;
	int                     stall_left;
	int unsigned            stall_pick;

	always #10 clk = ~clk;

	joint_step_rate_limiter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.joint_index(joint_index),
		.position(position),
		.tick_end(tick_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_joint(out_joint),
		.command_position(command_position),
		.joint_reached(joint_reached),
		.last_joint(last_joint)
	);

	// ------------------------------------------------------------------
	// Model: goal words store and arm, measured words store, tick_end on a
	// measured word produces one command per joint.
	// ------------------------------------------------------------------
	task automatic model_word(input logic kind, input logic [2:0] j,
			input logic signed [31:0] p, input logic tick, input logic typed,
			input logic [31:0] typed_cmd, input logic typed_reached);
		longint    diff [ACTIVE];
		longint    peak;
		longint    mag;
		longint    step;
		longint    cmd;
		cmd_word_t w;
		int        i;
		if (kind == REQ_GOAL) begin
			// out-of-range joints neither store nor arm; tick_end is ignored here
			if (j < ACTIVE) begin
				goal_pos[j] = p;
				goal_armed = 1'b1;
			end
		end else begin
			if (j < ACTIVE)
				meas_pos[j] = p;
			if (tick) begin
				// largest |goal - measured| over all joints, exact in 33+ bits
				peak = 0;
				for (i = 0; i < ACTIVE; i++) begin
					diff[i] = goal_armed ? longint'(goal_pos[i]) - longint'(meas_pos[i]) : 0;
					mag = (diff[i] < 0) ? -diff[i] : diff[i];
					if (mag > peak)
						peak = mag;
				end
				for (i = 0; i < ACTIVE; i++) begin
					mag = (diff[i] < 0) ? -diff[i] : diff[i];
					// scale down, truncating toward zero, keeps the direction
					if (goal_armed && peak > longint'({1'b0, step_limit_q}))
						mag = (mag * longint'({1'b0, step_limit_q})) / peak;
					step = (diff[i] < 0) ? -mag : mag;
					cmd = longint'(meas_pos[i]) + step;
					if (cmd > 64'sd2147483647)
						cmd = 64'sd2147483647;
					if (cmd < -64'sd2147483648)
						cmd = -64'sd2147483648;
					w.joint = 3'(i);
					w.cmd = cmd[31:0];
					w.reached = goal_armed && (mag <= longint'({1'b0, reach_tol_q}));
					w.last = (i == ACTIVE - 1);
					if (typed) begin
						w.cmd = typed_cmd;
						w.reached = typed_reached;
					end
					expected_cmds.push_back(w);
				end
			end
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
	endtask

	task automatic check_command();
		cmd_word_t want;
		if (expected_cmds.size() == 0) begin
			flag_mismatch("command word with none pending, out_joint", 32'd0, 32'(out_joint));
			return;
		end
		want = expected_cmds.pop_front();
		if (out_joint !== want.joint)
			flag_mismatch("out_joint", 32'(want.joint), 32'(out_joint));
		if (command_position !== want.cmd)
			flag_mismatch("command_position", want.cmd, command_position);
		if (joint_reached !== want.reached)
			flag_mismatch("joint_reached", 32'(want.reached), 32'(joint_reached));
		if (last_joint !== want.last)
			flag_mismatch("last_joint", 32'(want.last), 32'(last_joint));
	endtask

	// Both handshakes are observed on the clock edge; all inputs change by NBA, so
	// these reads see the values from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				model_word(req_type, joint_index, position, tick_end,
					hand_set, hand_cmd, hand_reached);
			if (out_valid && !out_stall)
				check_command();
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver back-pressure: bursts of stall, mostly short, some long, with
	// occasional long quiet stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			out_stall <= (stall_pick < 40);
			if (stall_pick < 30)
				stall_left <= $urandom_range(0, 2);
			else if (stall_pick < 40)
				stall_left <= $urandom_range(10, 50);
			else if (stall_pick < 92)
				stall_left <= $urandom_range(0, 6);
			else
				stall_left <= $urandom_range(40, 150);
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Mostly near a reference angle so steps get small enough to reach, else
	// rail values or anything at all.
	function automatic logic [31:0] pick_pos(input logic [31:0] base);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return base + 32'($urandom_range(0, 4000)) - 32'd2000;
		if (r < 65)
			return base + 32'($urandom_range(0, 400000)) - 32'd200000;
		if (r < 75)
			return r[0] ? 32'h7FFFFFFF : 32'h80000000;
		return $urandom;
	endfunction

	// Called at a clock edge; returns at the edge where the word was taken, with
	// in_valid still high so a back-to-back word keeps it up.
	task automatic send_word(input req_t kind, input logic [2:0] joint,
			input logic [31:0] pos, input logic tick, input logic typed,
			input logic [31:0] typed_cmd, input logic typed_reached);
		int gap;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		joint_index <= joint;
		position <= pos;
		tick_end <= tick;
		hand_set <= typed;
		hand_cmd <= typed_cmd;
		hand_reached <= typed_reached;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// Sender holds off until every command has come back and the block has had
	// time to finish any tick.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (TICK_DRAIN) @(posedge clk);
	endtask

	// Both registers are written back to back; cfg_ready is waited for anyway.
	task automatic program_regs(input logic [LIM_W-1:0] limit, input logic [LIM_W-1:0] tol);
		cfg_valid <= 1'b1;
		cfg_index <= REG_STEP_LIMIT;
		cfg_data <= limit;
		do @(posedge clk); while (!cfg_ready);
		step_limit_q = limit;
		cfg_index <= REG_REACH_TOL;
		cfg_data <= tol;
		do @(posedge clk); while (!cfg_ready);
		reach_tol_q = tol;
		cfg_valid <= 1'b0;
	endtask

	// A well-formed tick: a few goal updates, then every joint measured once in
	// shuffled order, the last one closing the tick.
	task automatic random_tick();
		int order [ACTIVE];
		int n_goals;
		int i;
		int j;
		int k;
		int tmp;
		n_goals = $urandom_range(0, 3);
		for (i = 0; i < n_goals; i++) begin
			j = $urandom_range(0, ACTIVE - 1);
			send_word(REQ_GOAL, 3'(j), pick_pos(meas_pos[j]), $urandom_range(0, 7) == 0,
				1'b0, 32'd0, 1'b0);
		end
		for (i = 0; i < ACTIVE; i++)
			order[i] = i;
		for (i = ACTIVE - 1; i > 0; i--) begin
			k = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[k];
			order[k] = tmp;
		end
		for (i = 0; i < ACTIVE; i++)
			send_word(REQ_MEAS, 3'(order[i]), pick_pos(goal_pos[order[i]]),
				i == ACTIVE - 1, 1'b0, 32'd0, 1'b0);
	endtask

	task automatic add_row(input req_t kind, input logic [2:0] joint, input logic [31:0] pos,
			input logic tick, input logic typed, input logic [31:0] typed_cmd,
			input logic typed_reached);
		plan.push_back(plan_row_t'{kind, joint, pos, tick, typed, typed_cmd, typed_reached});
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [LIM_W-1:0] limit;
		logic [LIM_W-1:0] tol;
		int               r;
		int               ph;
		int               phase_start;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_STEP_LIMIT;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_GOAL;
		joint_index = '0;
		position = '0;
		tick_end = 1'b0;
		hand_set = 1'b0;
		hand_cmd = '0;
		hand_reached = 1'b0;
		sender_gaps = 1'b1;
		goal_armed = 1'b0;
		step_limit_q = STEP_LIMIT_RST;
		reach_tol_q = REACH_TOL_RST;
		for (r = 0; r < ACTIVE; r++) begin
			goal_pos[r] = '0;
			meas_pos[r] = '0;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words, reset register values.
		// Not armed: every joint commands its own measurement, never reached.
		// All joints measured at the top rail first, so no tick reads an empty slot.
		for (r = 0; r < ACTIVE; r++)
			add_row(REQ_MEAS, 3'(r), 32'h7FFFFFFF, r == ACTIVE - 1,
				r == ACTIVE - 1, 32'h7FFFFFFF, 1'b0);
		// goal for a joint out of range with tick_end: ignored, must not arm
		add_row(REQ_GOAL, 3'd7, 32'h12345678, 1'b1, 1'b0, 32'd0, 1'b0);
		// measured out of range still ends the tick but stores nothing
		add_row(REQ_MEAS, 3'd7, 32'h80000000, 1'b1, 1'b1, 32'h7FFFFFFF, 1'b0);
		// bottom rail everywhere, still unarmed
		for (r = 0; r < ACTIVE; r++)
			add_row(REQ_MEAS, 3'(r), 32'h80000000, r == ACTIVE - 1,
				r == ACTIVE - 1, 32'h80000000, 1'b0);
		// arm with a zero goal: all diffs are 2^31, each clipped to exactly
		// step_limit (16777), which is above tolerance
		add_row(REQ_GOAL, 3'd3, 32'h00000000, 1'b0, 1'b0, 32'd0, 1'b0);
		add_row(REQ_MEAS, 3'd0, 32'h80000000, 1'b1, 1'b1, 32'h80004189, 1'b0);
		// widest diffs of both signs
		add_row(REQ_GOAL, 3'd0, 32'h7FFFFFFF, 1'b0, 1'b0, 32'd0, 1'b0);
		add_row(REQ_GOAL, 3'd1, 32'h80000000, 1'b0, 1'b0, 32'd0, 1'b0);
		add_row(REQ_MEAS, 3'd1, 32'h7FFFFFFF, 1'b0, 1'b0, 32'd0, 1'b0);
		add_row(REQ_MEAS, 3'd0, 32'h80000000, 1'b1, 1'b0, 32'd0, 1'b0);
		// small negative goal against a small positive measurement
		add_row(REQ_GOAL, 3'd5, 32'hFFFFFFFF, 1'b0, 1'b0, 32'd0, 1'b0);
		add_row(REQ_MEAS, 3'd5, 32'h00000001, 1'b1, 1'b0, 32'd0, 1'b0);

		for (r = 0; r < plan.size(); r++)
			send_word(plan[r].kind, plan[r].joint, plan[r].pos, plan[r].tick,
				plan[r].hand_set, plan[r].hand_cmd, plan[r].hand_reached);
		wait_idle();

		// Random phases, each under its own register setting; registers only change
		// once the block has gone idle.
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					// zero limit: armed joints never move and always count as reached
					limit = '0;
					tol = '0;
				end
				1: begin
					limit = '1;
					tol = '1;
				end
				2: begin
					limit = LIM_W'($urandom_range(1, 100000));
					tol = LIM_W'($urandom_range(0, 3000));
				end
				3: begin
					limit = LIM_W'($urandom_range(0, 32'h7FFFFFFF));
					tol = LIM_W'($urandom_range(0, 32'h7FFFFFFF));
				end
				default: begin
					limit = STEP_LIMIT_RST;
					tol = REACH_TOL_RST;
				end
			endcase
			program_regs(limit, tol);
			// one phase runs the sender flat out
			sender_gaps = (ph != 1);
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS) begin
				if ($urandom_range(0, 99) < 75)
					random_tick();
				else
					send_word(req_t'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
						$urandom, $urandom_range(0, 3) == 0, 1'b0, 32'd0, 1'b0);
			end
			wait_idle();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
